// ----- hw/rtl/mbss_pkg.sv -----
// Shared types and constants for the masked byte signature scanner.
package mbss_pkg;

  // Register file geometry: 64-bit registers at byte address 8*i.
  localparam int unsigned AddrBits   = 6;
  localparam int unsigned DataBits   = 64;
  localparam int unsigned IndexBits  = 3;
  localparam int unsigned SigBytes   = 16;
  localparam int unsigned LenBits    = 5;
  localparam int unsigned LimitBits  = 8;
  localparam int unsigned OutOffBits = 32;

  // Register indexes.
  typedef enum logic [IndexBits-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_MASK = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_HIT_LIMIT    = 3'd4,
    REG_ENABLE       = 3'd5
  } reg_idx_t;

  // Reset values of the configuration.
  localparam logic [LenBits-1:0]   LenReset   = 5'd1;
  localparam logic [LimitBits-1:0] LimitReset = 8'd255;

  // Configuration as seen by the scan logic.
  typedef struct packed {
    logic [63:0]           pattern_low;
    logic [63:0]           pattern_high;
    logic [SigBytes-1:0]   pattern_mask;
    logic [LenBits-1:0]    pattern_length;
    logic [LimitBits-1:0]  hit_limit;
    logic                  pattern_enable;
  } cfg_t;

endpackage

// ----- hw/rtl/masked_byte_signature_scanner_top.sv -----
// Top level of the masked byte signature scanner.
//
//   Port group      Direction  Handshake             Payload
//   in request      in         in_valid / in_stall   data_byte, buffer_end
//   out request     out        out_valid / out_stall match_offset, hit_number,
//                                                    limit_reached
//   configuration   in         APB psel/penable      paddr, pwdata, prdata
//
// One byte per cycle is taken while in_stall is low; a hit is presented once its byte has
// passed the input register and then the result register.
// The scan of one byte is a single pass of parallel compares between the two.
// Reset clears the control state, offset and hit count; the window is not cleared.
// A stalled result holds the result register and, once the input register is
// also full, in_stall rises.
module masked_byte_signature_scanner_top #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          buffer_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   match_offset,
  output logic [7:0]                    hit_number,
  output logic                          limit_reached,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbss_pkg::AddrBits-1:0] paddr,
  input  logic [mbss_pkg::DataBits-1:0] pwdata,
  output logic [mbss_pkg::DataBits-1:0] prdata,
  output logic                          pready
);
  import mbss_pkg::*;

  cfg_t                               cfg;
  logic                               s_valid;
  logic [7:0]                         s_data;
  logic                               s_last;
  logic                               advance;
  logic [MAX_PATTERN_BYTES-1:0][7:0]  window;
  logic [MAX_PATTERN_BYTES-1:0][7:0]  window_next;
  logic [OFFSET_BITS-1:0]             byte_offset;
  logic [OFFSET_BITS-1:0]             offset_plus;
  logic [OFFSET_BITS-1:0]             start_offset;
  logic [OFFSET_BITS+31:0]            start_ext;
  logic [LimitBits-1:0]               hit_count;
  logic [LimitBits-1:0]               count_next;
  logic [LimitBits-1:0]               limit_eff;
  logic                               counted;
  logic                               enough_bytes;
  logic                               pattern_hit;
  logic                               hit_fire;

  mbss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The input register moves on whenever the result register can take a request.
  assign advance  = s_valid && (!out_valid || !out_stall);
  assign in_stall = s_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_data <= data_byte;
      s_last <= buffer_end;
    end
  end

  // Window with the staged byte shifted in at entry 0.
  assign window_next = {window[MAX_PATTERN_BYTES-2:0], s_data};

  mbss_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_match (
    .window      (window_next),
    .cfg         (cfg),
    .pattern_hit (pattern_hit)
  );

  // Offset, limit and enable qualification of the compare.
  assign counted      = byte_offset != '1;
  assign offset_plus  = byte_offset + OFFSET_BITS'(1);
  assign enough_bytes = offset_plus >= OFFSET_BITS'(cfg.pattern_length);
  assign start_offset = offset_plus - OFFSET_BITS'(cfg.pattern_length);
  assign start_ext    = {32'd0, start_offset};
  assign limit_eff    = (cfg.hit_limit == '0) ? LimitBits'(1) : cfg.hit_limit;
  assign count_next   = hit_count + LimitBits'(1);
  assign hit_fire     = counted && cfg.pattern_enable && enough_bytes &&
                        (hit_count < limit_eff) && pattern_hit;

  // Per-buffer state, cleared after the byte that ends the buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      hit_count   <= '0;
    end else if (advance) begin
      if (s_last) begin
        byte_offset <= '0;
        hit_count   <= '0;
      end else begin
        if (counted) begin
          byte_offset <= offset_plus;
        end
        if (hit_fire) begin
          hit_count <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      window <= window_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hit_fire;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit_fire) begin
      match_offset  <= start_ext[31:0];
      hit_number    <= count_next;
      limit_reached <= count_next >= limit_eff;
    end
  end

  // Checks on the scan control.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    advance && hit_fire && !s_last |=> hit_count == hit_number)
    else $error("hit count differs from reported hit number");

  a_disabled_quiet: assert property (@(posedge clk) disable iff (rst)
    advance && !cfg.pattern_enable |=> !out_valid)
    else $error("hit reported while scanning is disabled");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    advance && s_last |=> byte_offset == '0 && hit_count == '0)
    else $error("buffer state not cleared after buffer end");

endmodule

// ----- hw/rtl/mbss_regs.sv -----
// APB configuration register file of the signature scanner.
module mbss_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbss_pkg::AddrBits-1:0] paddr,
  input  logic [mbss_pkg::DataBits-1:0] pwdata,
  output logic [mbss_pkg::DataBits-1:0] prdata,
  output logic                          pready,
  output mbss_pkg::cfg_t                cfg
);
  import mbss_pkg::*;

  logic                 wr_en;
  logic [IndexBits-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrBits-1:AddrBits-IndexBits];

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low    <= '0;
      cfg.pattern_high   <= '0;
      cfg.pattern_mask   <= '0;
      cfg.pattern_length <= LenReset;
      cfg.hit_limit      <= LimitReset;
      cfg.pattern_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN_LOW:  cfg.pattern_low    <= pwdata;
        REG_PATTERN_HIGH: cfg.pattern_high   <= pwdata;
        REG_PATTERN_MASK: cfg.pattern_mask   <= pwdata[SigBytes-1:0];
        REG_PATTERN_LEN:  cfg.pattern_length <= pwdata[LenBits-1:0];
        REG_HIT_LIMIT:    cfg.hit_limit      <= pwdata[LimitBits-1:0];
        REG_ENABLE:       cfg.pattern_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_LOW:  prdata = cfg.pattern_low;
      REG_PATTERN_HIGH: prdata = cfg.pattern_high;
      REG_PATTERN_MASK: prdata = DataBits'(cfg.pattern_mask);
      REG_PATTERN_LEN:  prdata = DataBits'(cfg.pattern_length);
      REG_HIT_LIMIT:    prdata = DataBits'(cfg.hit_limit);
      REG_ENABLE:       prdata = DataBits'(cfg.pattern_enable);
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/mbss_match.sv -----
// Parallel masked compare of the byte window against the signature.
module mbss_match #(
  parameter int unsigned MAX_PATTERN_BYTES = 16
) (
  input  logic [MAX_PATTERN_BYTES-1:0][7:0] window,
  input  mbss_pkg::cfg_t                    cfg,
  output logic                              pattern_hit
);
  import mbss_pkg::*;

  localparam int unsigned IdxBits = $clog2(MAX_PATTERN_BYTES);

  logic [2*64-1:0]              pattern;
  logic [MAX_PATTERN_BYTES-1:0] in_len;
  logic [MAX_PATTERN_BYTES-1:0] byte_ok;
  logic                         len_valid;
  logic                         mask_any;

  assign pattern = {cfg.pattern_high, cfg.pattern_low};

  // Signature byte i lines up with window entry length-1-i (entry 0 newest).
  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_byte
    logic [LenBits-1:0] pos;
    assign pos        = cfg.pattern_length - LenBits'(1) - LenBits'(i);
    assign in_len[i]  = LenBits'(i) < cfg.pattern_length;
    assign byte_ok[i] = !(in_len[i] && cfg.pattern_mask[i]) ||
                        (window[pos[IdxBits-1:0]] == pattern[i*8 +: 8]);
  end

  // A usable pattern needs a legal length and at least one fixed byte.
  assign len_valid = (cfg.pattern_length != '0) &&
                     (cfg.pattern_length <= LenBits'(MAX_PATTERN_BYTES));
  assign mask_any  = |(cfg.pattern_mask[MAX_PATTERN_BYTES-1:0] & in_len);

  assign pattern_hit = len_valid && mask_any && (&byte_ok);

endmodule
